FILE: rtl/cfbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbf_pkg
// Shared types and constants for the centered block FIR filter.
// ----------------------------------------------------------------------------
package cfbf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TAP_W      = 16;
    localparam int PROD_W     = SAMPLE_W + TAP_W;
    localparam int ACC_W      = 40;
    localparam int ROUND_BITS = 14;
    localparam int POS_W      = 7;
    localparam int IDX_W      = 6;

    localparam logic [POS_W-1:0]          POS_MAX = '1;
    localparam logic signed [TAP_W-1:0]   TAP_ONE = 16'sd16384;
    localparam logic signed [ACC_W-1:0]   ROUND_HALF = 40'sd8192;
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic valid;
        logic tap_ok;
        logic center;
    } t_mac_ctl;

endpackage

FILE: rtl/cfbf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cfbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cfbf_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbf_mac
// Multiply-accumulate pipeline with round-half-up and 16-bit saturation.
// ----------------------------------------------------------------------------
module cfbf_mac
    import cfbf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctl                   i_ctl,
    input  logic signed [TAP_W-1:0]    i_tap_rdata,
    input  logic signed [SAMPLE_W-1:0] i_hist_rdata,
    output logic signed [SAMPLE_W-1:0] o_result
);

    t_mac_ctl                  r_s1;
    logic                      r_prod_v;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    logic signed [TAP_W-1:0]   tap;
    logic signed [ACC_W-1:0]   rounded;
    logic signed [ACC_W-1:0]   shifted;

    always_comb begin
        if (r_s1.tap_ok) begin
            tap = i_tap_rdata;
        end else if (r_s1.center) begin
            tap = TAP_ONE;
        end else begin
            tap = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1     <= '0;
            r_prod_v <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_s1     <= i_ctl;
            r_prod_v <= r_s1.valid;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (r_prod_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= tap * i_hist_rdata;
    end

    always_comb begin
        rounded = r_acc + ROUND_HALF;
        shifted = rounded >>> ROUND_BITS;
        if (shifted > ACC_W'(SAT_MAX)) begin
            o_result = SAT_MAX;
        end else if (shifted < ACC_W'(SAT_MIN)) begin
            o_result = SAT_MIN;
        end else begin
            o_result = shifted[SAMPLE_W-1:0];
        end
    end

endmodule

FILE: rtl/centered_fir_block_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_fir_block_filter
// Centered, zero-padded FIR over blocks of Q1.15 samples with Q2.14 taps.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (i_valid/o_stall) carry either a tap load (i_req_type = 0)
//   or one audio sample (i_req_type = 1). Output beats (o_valid/i_stall)
//   carry filtered samples with run_last and block_end flags.
//   i_cfg_wr_en/i_cfg_wr_data write the bypass bit; write it while idle.
//   Tap loads give no output beat. Bypass samples pass through the S_EMIT
//   state into the output register, waiting there while the receiver stalls.
//   Each filtered output runs one multiply-accumulate per tap through the
//   tap and history memories. The sample marked last flushes up to
//   TAPS/2 + 1 results. o_stall stays high while results are computed.
//   A finished result waits in the output register while the next input
//   beat is taken; a stalled receiver holds the computation at its end.
//   Reset sets bypass, restores identity taps (center tap 1.0) and empties
//   the current block; no clearing pass is needed.
// ----------------------------------------------------------------------------
module centered_fir_block_filter
    import cfbf_pkg::*;
#(
    parameter int TAPS = 63
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_req_type,
    input  logic [IDX_W-1:0]           i_tap_index,
    input  logic signed [TAP_W-1:0]    i_tap_value,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic                       i_block_last,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_run_last,
    output logic                       o_block_end,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_wr_data
);

    localparam int HALF  = TAPS / 2;
    localparam int DEPTH = 2 * HALF + 1;
    localparam int HW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (TAPS > 1) ? $clog2(TAPS) : 1;

    t_state                      r_state, n_state;
    logic [POS_W-1:0]            r_j, n_j;
    logic                        r_drain, n_drain;
    logic [POS_W-1:0]            r_d, n_d;
    logic [POS_W-1:0]            r_p, n_p;
    logic                        r_last, n_last;
    logic                        r_byp, n_byp;
    logic [POS_W-1:0]            r_pos, n_pos;
    logic [HW-1:0]               r_wptr, n_wptr;
    logic                        r_bypass;
    logic [TAPS-1:0]             r_tap_v;
    logic signed [SAMPLE_W-1:0]  r_byp_sample;
    logic                        r_out_v, n_out_v;
    logic signed [SAMPLE_W-1:0]  r_out_sample, n_out_sample;
    logic                        r_out_rl, n_out_rl;
    logic                        r_out_be, n_out_be;

    logic                        in_acc;
    logic                        tap_we;
    logic                        hist_we;
    logic [HW-1:0]               wptr_inc;
    logic signed [8:0]           k;
    logic signed [8:0]           a;
    logic                        k_ok;
    logic [HW-1:0]               hist_raddr;
    logic signed [TAP_W-1:0]     tap_rdata;
    logic signed [SAMPLE_W-1:0]  hist_rdata;
    logic signed [SAMPLE_W-1:0]  mac_result;
    logic                        out_free;
    logic                        more;
    t_mac_ctl                    mac_ctl;

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign tap_we  = in_acc && (i_req_type == REQ_LOAD)
                     && (POS_W'(i_tap_index) < POS_W'(TAPS));
    assign hist_we = in_acc && (i_req_type == REQ_SAMPLE) && !r_bypass;
    assign wptr_inc = (r_wptr == HW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;

    always_comb begin
        k    = 9'(r_d) + 9'(HALF) - 9'(r_j);
        k_ok = !k[8] && (k < 9'(DEPTH)) && (k <= $signed({2'b00, r_p}));
        a    = 9'(r_wptr) - k;
        if (a[8]) begin
            a = a + 9'(DEPTH);
        end
        hist_raddr = a[HW-1:0];
    end

    cfbf_ram #(.WIDTH(TAP_W), .DEPTH(TAPS)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (TW'(i_tap_index)),
        .i_wdata (i_tap_value),
        .i_raddr (r_j[TW-1:0]),
        .o_rdata (tap_rdata)
    );

    cfbf_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (wptr_inc),
        .i_wdata (i_sample_in),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    cfbf_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (mac_ctl),
        .i_tap_rdata  (tap_rdata),
        .i_hist_rdata (hist_rdata),
        .o_result     (mac_result)
    );

    always_comb begin
        n_state      = r_state;
        n_j          = r_j;
        n_drain      = r_drain;
        n_d          = r_d;
        n_p          = r_p;
        n_last       = r_last;
        n_byp        = r_byp;
        n_pos        = r_pos;
        n_wptr       = r_wptr;
        n_out_v      = r_out_v && i_stall;
        n_out_sample = r_out_sample;
        n_out_rl     = r_out_rl;
        n_out_be     = r_out_be;
        mac_ctl      = '0;
        out_free     = !r_out_v || !i_stall;
        more         = r_last && !r_byp && (r_d != '0);

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_req_type == REQ_SAMPLE)) begin
                    n_last = i_block_last;
                    if (r_bypass) begin
                        n_byp   = 1'b1;
                        n_pos   = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_byp  = 1'b0;
                        n_wptr = wptr_inc;
                        n_p    = r_pos;
                        n_j    = '0;
                        if (i_block_last) begin
                            n_d           = (r_pos < POS_W'(HALF)) ? r_pos : POS_W'(HALF);
                            n_pos         = '0;
                            n_state       = S_MAC;
                            mac_ctl.clear = 1'b1;
                        end else begin
                            n_d = POS_W'(HALF);
                            if (r_pos != POS_MAX) begin
                                n_pos = r_pos + 1'b1;
                            end
                            if (r_pos >= POS_W'(HALF)) begin
                                n_state       = S_MAC;
                                mac_ctl.clear = 1'b1;
                            end
                        end
                    end
                end
            end
            S_MAC: begin
                mac_ctl.valid  = k_ok;
                mac_ctl.tap_ok = r_tap_v[r_j[TW-1:0]];
                mac_ctl.center = (r_j == POS_W'(HALF));
                if (r_j == POS_W'(TAPS - 1)) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_v = 1'b1;
                    if (r_byp) begin
                        n_out_sample = r_byp_sample;
                        n_out_rl     = 1'b1;
                        n_out_be     = r_last;
                    end else begin
                        n_out_sample = mac_result;
                        n_out_rl     = !r_last || (r_d == '0);
                        n_out_be     = r_last && (r_d == '0);
                    end
                    if (more) begin
                        n_d           = r_d - 1'b1;
                        n_j           = '0;
                        n_state       = S_MAC;
                        mac_ctl.clear = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_j      <= '0;
            r_drain  <= 1'b0;
            r_d      <= '0;
            r_p      <= '0;
            r_last   <= 1'b0;
            r_byp    <= 1'b0;
            r_pos    <= '0;
            r_wptr   <= '0;
            r_bypass <= 1'b1;
            r_tap_v  <= '0;
            r_out_v  <= 1'b0;
            r_out_rl <= 1'b0;
            r_out_be <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_j      <= n_j;
            r_drain  <= n_drain;
            r_d      <= n_d;
            r_p      <= n_p;
            r_last   <= n_last;
            r_byp    <= n_byp;
            r_pos    <= n_pos;
            r_wptr   <= n_wptr;
            r_out_v  <= n_out_v;
            r_out_rl <= n_out_rl;
            r_out_be <= n_out_be;
            if (i_cfg_wr_en) begin
                r_bypass <= i_cfg_wr_data;
            end
            if (tap_we) begin
                r_tap_v[TW'(i_tap_index)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sample <= n_out_sample;
        if (in_acc) begin
            r_byp_sample <= i_sample_in;
        end
    end

    assign o_valid      = r_out_v;
    assign o_sample_out = r_out_sample;
    assign o_run_last   = r_out_rl;
    assign o_block_end  = r_out_be;

    a_mac_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC && r_j == POS_W'(TAPS - 1)) |=> (r_state == S_DRAIN))
        else $error("tap sweep did not end in drain");

    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr <= HW'(DEPTH - 1))
        else $error("history pointer out of range");

    a_delay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_d <= POS_W'(HALF)))
        else $error("output delay beyond half width");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (!r_out_v || !i_stall)) |=> o_valid)
        else $error("result not loaded into output register");

endmodule
